// ----- rtl/assert_macros.svh -----
// Assertion helpers for the fetch unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication or expression on every clock edge outside reset.
`define TBPF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define TBPF_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/tbpf_pkg.sv -----
package tbpf_pkg;

  // Video memory geometry: two byte banks, even and odd addresses
  localparam int MEM_BYTES = 8192;
  localparam int ADDR_W    = $clog2(MEM_BYTES);
  localparam int BANK_W    = ADDR_W - 1;

  // Item operations
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_RENDER = 2'd1;
  localparam logic [1:0] OP_FRAME  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_LCD_CONTROL = 3'd0;
  localparam logic [2:0] REG_SCROLL_X    = 3'd1;
  localparam logic [2:0] REG_SCROLL_Y    = 3'd2;
  localparam logic [2:0] REG_WINDOW_X    = 3'd3;
  localparam logic [2:0] REG_WINDOW_Y    = 3'd4;
  localparam logic [2:0] REG_BG_PALETTE  = 3'd5;

  // Control bit positions
  localparam int LCDC_BG_ENABLE  = 0;
  localparam int LCDC_BG_MAP     = 3;
  localparam int LCDC_DATA_UNSIG = 4;
  localparam int LCDC_WIN_ENABLE = 5;
  localparam int LCDC_WIN_MAP    = 6;

  // Window position limits
  localparam logic [7:0] WX_OFFSET = 8'd7;
  localparam logic [7:0] WX_LIMIT  = 8'd168;

  // Map base upper bits: maps sit at 0x1800 and 0x1C00
  localparam logic [1:0] MAP_BASE_HI = 2'b11;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] mem_address;
    logic [7:0]        mem_data;
    logic [7:0]        line;
    logic [7:0]        column;
    logic              line_end;
  } in_req_t;

  typedef struct packed {
    logic [1:0] shade;
    logic [1:0] color_id;
    logic       from_window;
  } out_pix_t;

  typedef struct packed {
    logic [7:0] lcd_control;
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic [7:0] window_x;
    logic [7:0] window_y;
    logic [7:0] bg_palette;
  } cfg_regs_t;

  // Map lookup for one pixel request
  typedef struct packed {
    logic [ADDR_W-1:0] map_addr;
    logic              enabled;
    logic              from_window;
    logic              data_unsigned;
    logic [2:0]        fine_x;
    logic [2:0]        fine_y;
  } fetch_t;

endpackage

// ----- rtl/tile_background_pixel_fetch_unit.sv -----
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_req  (tbpf_pkg::in_req_t)
// out       output     out_valid / out_stall out_pix (tbpf_pkg::out_pix_t)
// cfg       input      cfg_wr_en            cfg_index, cfg_wdata
//
// A pixel request uses the video memory read ports for the map read, then for the dependent
// tile-plane read of both banks. A pixel enters once the last has left the map stage and the
// tile stage can move; writes enter every cycle unless a map read waits, frame starts every
// cycle. An accepted request passes the map stage, the tile stage and the output register.
// Reset (synchronous) clears the pipeline valids, the window line counter and the configuration
// registers, not memory contents. A stalled output holds the result and the last stages.
`include "assert_macros.svh"

module tile_background_pixel_fetch_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tbpf_pkg::in_req_t   in_req,
  output logic                out_valid,
  input  logic                out_stall,
  output tbpf_pkg::out_pix_t  out_pix,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_wdata
);

  tbpf_pkg::cfg_regs_t cfg;
  tbpf_pkg::fetch_t    fetch;

  // Stage 1: map byte in flight
  logic       s1_valid;
  logic       s1_bank;
  logic       s1_enabled;
  logic       s1_from_window;
  logic       s1_unsigned;
  logic [2:0] s1_fine_x;
  logic [2:0] s1_fine_y;

  // Stage 2: tile plane bytes in flight
  logic       s2_valid;
  logic       s2_enabled;
  logic       s2_from_window;
  logic [2:0] s2_fine_x;

  logic s1_move;
  logic s2_move;
  logic render_ok;
  logic render_acc;
  logic write_acc;
  logic frame_acc;
  logic in_acc;

  logic [7:0]                  rdata_even;
  logic [7:0]                  rdata_odd;
  logic [7:0]                  entry;
  logic [tbpf_pkg::BANK_W-1:0] tile_idx;
  logic [tbpf_pkg::BANK_W-1:0] map_idx;
  logic                        map_bank;
  logic                        rd_en_even;
  logic                        rd_en_odd;
  logic [tbpf_pkg::BANK_W-1:0] rd_idx_even;
  logic [tbpf_pkg::BANK_W-1:0] rd_idx_odd;
  logic [2:0]                  bitpos;
  logic [1:0]                  cid;
  logic [7:0]                  pal_shift;

  // Flow control
  always_comb begin
    s2_move   = s2_valid && (!out_valid || !out_stall);
    s1_move   = s1_valid && (!s2_valid || s2_move);
    render_ok = !s1_valid && !(s2_valid && !s2_move);
    unique case (in_req.operation)
      tbpf_pkg::OP_RENDER: in_stall = !render_ok;
      tbpf_pkg::OP_WRITE:  in_stall = s1_valid && !s1_move;
      default:             in_stall = 1'b0;
    endcase
    in_acc     = in_valid && !in_stall;
    render_acc = in_acc && (in_req.operation == tbpf_pkg::OP_RENDER);
    write_acc  = in_acc && (in_req.operation == tbpf_pkg::OP_WRITE);
    frame_acc  = in_acc && (in_req.operation == tbpf_pkg::OP_FRAME);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tbpf_pkg::REG_LCD_CONTROL: cfg.lcd_control <= cfg_wdata;
        tbpf_pkg::REG_SCROLL_X:    cfg.scroll_x    <= cfg_wdata;
        tbpf_pkg::REG_SCROLL_Y:    cfg.scroll_y    <= cfg_wdata;
        tbpf_pkg::REG_WINDOW_X:    cfg.window_x    <= cfg_wdata;
        tbpf_pkg::REG_WINDOW_Y:    cfg.window_y    <= cfg_wdata;
        tbpf_pkg::REG_BG_PALETTE:  cfg.bg_palette  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tbpf_coord u_coord (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req        (in_req),
    .render_acc (render_acc),
    .frame_acc  (frame_acc),
    .fetch      (fetch)
  );

  // Read port steering: tile read of stage 1 or map read of a new request
  always_comb begin
    entry    = s1_bank ? rdata_odd : rdata_even;
    tile_idx = {!s1_unsigned && !entry[7], entry, s1_fine_y};
    map_idx  = fetch.map_addr[tbpf_pkg::ADDR_W-1:1];
    map_bank = fetch.map_addr[0];
    if (s1_move) begin
      rd_en_even  = 1'b1;
      rd_en_odd   = 1'b1;
      rd_idx_even = tile_idx;
      rd_idx_odd  = tile_idx;
    end else begin
      rd_en_even  = render_acc && !map_bank;
      rd_en_odd   = render_acc && map_bank;
      rd_idx_even = map_idx;
      rd_idx_odd  = map_idx;
    end
  end

  tbpf_vram u_vram (
    .clk         (clk),
    .wr_en       (write_acc),
    .wr_addr     (in_req.mem_address),
    .wr_data     (in_req.mem_data),
    .rd_en_even  (rd_en_even),
    .rd_idx_even (rd_idx_even),
    .rd_en_odd   (rd_en_odd),
    .rd_idx_odd  (rd_idx_odd),
    .rdata_even  (rdata_even),
    .rdata_odd   (rdata_odd)
  );

  // Pipeline stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (render_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (s2_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Color id from the tile planes, then palette lookup
  always_comb begin
    bitpos    = 3'd7 - s2_fine_x;
    cid       = s2_enabled ? {rdata_odd[bitpos], rdata_even[bitpos]} : 2'd0;
    pal_shift = cfg.bg_palette >> {cid, 1'b0};
  end

  // Pipeline payloads
  always_ff @(posedge clk) begin
    if (render_acc) begin
      s1_bank        <= map_bank;
      s1_enabled     <= fetch.enabled;
      s1_from_window <= fetch.from_window;
      s1_unsigned    <= fetch.data_unsigned;
      s1_fine_x      <= fetch.fine_x;
      s1_fine_y      <= fetch.fine_y;
    end
    if (s1_move) begin
      s2_enabled     <= s1_enabled;
      s2_from_window <= s1_from_window;
      s2_fine_x      <= s1_fine_x;
    end
    if (s2_move) begin
      out_pix.shade       <= pal_shift[1:0];
      out_pix.color_id    <= cid;
      out_pix.from_window <= s2_from_window;
    end
  end

  `TBPF_NEVER(a_port_conflict, clk, rst, render_acc && s1_move, "map read collides with tile read")
  `TBPF_ASSERT(a_write_order, clk, rst, (write_acc && s1_valid) |-> s1_move, "write passes a pending tile read")
  `TBPF_ASSERT(a_render_enters, clk, rst, render_acc |=> s1_valid, "accepted request lost before map stage")
  `TBPF_ASSERT(a_s2_holds, clk, rst, (s2_valid && !s2_move) |=> s2_valid, "stalled tile stage dropped")

endmodule

// ----- rtl/tbpf_vram.sv -----
module tbpf_vram (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [tbpf_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [7:0]                   wr_data,
  input  logic                         rd_en_even,
  input  logic [tbpf_pkg::BANK_W-1:0]  rd_idx_even,
  input  logic                         rd_en_odd,
  input  logic [tbpf_pkg::BANK_W-1:0]  rd_idx_odd,
  output logic [7:0]                   rdata_even,
  output logic [7:0]                   rdata_odd
);

  localparam int BANK_DEPTH = tbpf_pkg::MEM_BYTES / 2;

  logic [7:0] bank_even [BANK_DEPTH];
  logic [7:0] bank_odd  [BANK_DEPTH];

  // Even bank: read returns the old byte on a same-cycle write
  always_ff @(posedge clk) begin
    if (wr_en && !wr_addr[0]) begin
      bank_even[wr_addr[tbpf_pkg::ADDR_W-1:1]] <= wr_data;
    end
    if (rd_en_even) begin
      rdata_even <= bank_even[rd_idx_even];
    end
  end

  // Odd bank
  always_ff @(posedge clk) begin
    if (wr_en && wr_addr[0]) begin
      bank_odd[wr_addr[tbpf_pkg::ADDR_W-1:1]] <= wr_data;
    end
    if (rd_en_odd) begin
      rdata_odd <= bank_odd[rd_idx_odd];
    end
  end

endmodule

// ----- rtl/tbpf_coord.sv -----
module tbpf_coord (
  input  logic                clk,
  input  logic                rst,
  input  tbpf_pkg::cfg_regs_t cfg,
  input  tbpf_pkg::in_req_t   req,
  input  logic                render_acc,
  input  logic                frame_acc,
  output tbpf_pkg::fetch_t    fetch
);

  logic [7:0] window_line;
  logic [7:0] wx_start;
  logic [7:0] px;
  logic [7:0] py;
  logic       win_on;
  logic       use_window;
  logic       map_sel;

  // Pick window or scrolled background coordinates
  always_comb begin
    wx_start   = cfg.window_x - tbpf_pkg::WX_OFFSET;
    win_on     = cfg.lcd_control[tbpf_pkg::LCDC_WIN_ENABLE] && (cfg.window_y <= req.line);
    use_window = win_on && (cfg.window_x >= tbpf_pkg::WX_OFFSET) && (req.column >= wx_start);
    if (use_window) begin
      px      = req.column - wx_start;
      py      = window_line;
      map_sel = cfg.lcd_control[tbpf_pkg::LCDC_WIN_MAP];
    end else begin
      px      = req.column + cfg.scroll_x;
      py      = req.line + cfg.scroll_y;
      map_sel = cfg.lcd_control[tbpf_pkg::LCDC_BG_MAP];
    end
    fetch.map_addr      = {tbpf_pkg::MAP_BASE_HI, map_sel, py[7:3], px[7:3]};
    fetch.enabled       = cfg.lcd_control[tbpf_pkg::LCDC_BG_ENABLE];
    fetch.from_window   = use_window && cfg.lcd_control[tbpf_pkg::LCDC_BG_ENABLE];
    fetch.data_unsigned = cfg.lcd_control[tbpf_pkg::LCDC_DATA_UNSIG];
    fetch.fine_x        = px[2:0];
    fetch.fine_y        = py[2:0];
  end

  // Window line counter: clear at frame start, advance at the end of a window line
  always_ff @(posedge clk) begin
    if (rst) begin
      window_line <= '0;
    end else if (frame_acc) begin
      window_line <= '0;
    end else if (render_acc && req.line_end && win_on && (cfg.window_x <= tbpf_pkg::WX_LIMIT)) begin
      window_line <= window_line + 8'd1;
    end
  end

endmodule
